/* rtl/core/led_blink_pattern_sequencer_core_assert.svh */
`ifndef LED_BLINK_PATTERN_SEQUENCER_CORE_ASSERT_SVH
`define LED_BLINK_PATTERN_SEQUENCER_CORE_ASSERT_SVH

// flag a condition that must never be seen outside reset
`define LBPS_ASSERT_NEVER(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("lbps: forbidden condition seen");

// flag a cause that is not followed by its effect in the next cycle
`define LBPS_ASSERT_NEXT(name, clk, rst, cause, effect) \
   name: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
      else $error("lbps: expected follow-up missing");

`endif

/* rtl/core/lbps_pkg.sv */
`timescale 1ns / 1ps

package lbps_pkg;

   localparam int PATTERN_DEPTH_DEFAULT = 16;
   localparam int TIME_BITS_DEFAULT     = 16;

   localparam int ACT_W   = 3;
   localparam int FIELD_W = 16;
   localparam int COUNT_W = 16;
   localparam int SLOT_W  = 4;
   localparam int LEN_W   = 5;

   localparam logic [ACT_W-1:0] ACT_TICK        = 3'd0;
   localparam logic [ACT_W-1:0] ACT_START_BLINK = 3'd1;
   localparam logic [ACT_W-1:0] ACT_START_SEQ   = 3'd2;
   localparam logic [ACT_W-1:0] ACT_STOP        = 3'd3;
   localparam logic [ACT_W-1:0] ACT_WRITE       = 3'd4;
   localparam logic [ACT_W-1:0] ACT_SET_LED     = 3'd5;

   typedef struct packed {
      logic [ACT_W-1:0]   action;
      logic [FIELD_W-1:0] on_time;
      logic [FIELD_W-1:0] off_time;
      logic [COUNT_W-1:0] repeat_count;
      logic               repeat_forever;
      logic [SLOT_W-1:0]  entry_index;
      logic [LEN_W-1:0]   seq_length;
      logic               led_level;
   } req_type;

   typedef struct packed {
      logic              led_on;
      logic              blinking;
      logic              accepted;
      logic [SLOT_W-1:0] pattern_now;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      logic    advance;
      req_type item;
   } step_ctl_type;

endpackage

/* rtl/core/lbps_chan_if.sv */
`timescale 1ns / 1ps

interface lbps_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/lbps_ram.sv */
`timescale 1ns / 1ps

module lbps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/lbps_engine.sv */
`timescale 1ns / 1ps

module lbps_engine #(
   parameter int TIME_BITS = lbps_pkg::TIME_BITS_DEFAULT,
   parameter int PATTERN_DEPTH = lbps_pkg::PATTERN_DEPTH_DEFAULT,
   parameter int ENTRY_W = 2 * TIME_BITS + lbps_pkg::COUNT_W + 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  lbps_pkg::step_ctl_type     ctl,
   input  logic [ENTRY_W-1:0]         entry,
   output lbps_pkg::rsp_type          result,
   output logic [lbps_pkg::LEN_W-1:0] pos_after
);

   localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
   localparam logic [lbps_pkg::COUNT_W-1:0] COUNT_MAX = {lbps_pkg::COUNT_W{1'b1}};

   logic                          running_ff, running_in;
   logic                          led_ff, led_in;
   logic [TIME_BITS-1:0]          elapsed_ff, elapsed_in;
   logic [TIME_BITS-1:0]          on_ff, on_in;
   logic [TIME_BITS-1:0]          off_ff, off_in;
   logic [lbps_pkg::COUNT_W-1:0]  rep_ff, rep_in;
   logic                          forever_ff, forever_in;
   logic [lbps_pkg::COUNT_W-1:0]  toggles_ff, toggles_in;
   logic                          in_seq_ff, in_seq_in;
   logic [lbps_pkg::LEN_W-1:0]    pos_ff, pos_in;
   logic [lbps_pkg::LEN_W-1:0]    total_ff, total_in;

   logic [TIME_BITS-1:0]          ent_on, ent_off, tick_el, wait_ms;
   logic [lbps_pkg::COUNT_W-1:0]  ent_rep, tick_tg;
   logic                          ent_forever, taken, len_ok;
   logic [lbps_pkg::LEN_W:0]      pos_next;

   assign ent_on      = entry[TIME_BITS-1:0];
   assign ent_off     = entry[2*TIME_BITS-1:TIME_BITS];
   assign ent_rep     = entry[2*TIME_BITS+lbps_pkg::COUNT_W-1:2*TIME_BITS];
   assign ent_forever = entry[ENTRY_W-1];

   assign len_ok = (ctl.item.seq_length != '0) &&
                   (32'(ctl.item.seq_length) <= PATTERN_DEPTH);
   assign tick_el  = (elapsed_ff != TIME_MAX) ? elapsed_ff + 1'b1 : elapsed_ff;
   assign wait_ms  = led_ff ? on_ff : off_ff;
   assign tick_tg  = (toggles_ff != COUNT_MAX) ? toggles_ff + 1'b1 : toggles_ff;
   assign pos_next = {1'b0, pos_ff} + 1'b1;

   always_comb begin
      running_in = running_ff;
      led_in     = led_ff;
      elapsed_in = elapsed_ff;
      on_in      = on_ff;
      off_in     = off_ff;
      rep_in     = rep_ff;
      forever_in = forever_ff;
      toggles_in = toggles_ff;
      in_seq_in  = in_seq_ff;
      pos_in     = pos_ff;
      total_in   = total_ff;
      taken      = 1'b0;
      unique case (ctl.item.action)
         lbps_pkg::ACT_TICK: begin
            if (running_ff) begin
               if (tick_el < wait_ms) begin
                  elapsed_in = tick_el;
               end else begin
                  elapsed_in = '0;
                  led_in     = !led_ff;
                  if (!forever_ff) begin
                     toggles_in = tick_tg;
                     if (tick_tg >= rep_ff) begin
                        if (in_seq_ff && (pos_next < {1'b0, total_ff})) begin
                           pos_in     = pos_next[lbps_pkg::LEN_W-1:0];
                           on_in      = ent_on;
                           off_in     = ent_off;
                           rep_in     = ent_rep;
                           forever_in = ent_forever;
                           toggles_in = '0;
                        end else begin
                           running_in = 1'b0;
                           in_seq_in  = 1'b0;
                           pos_in     = '0;
                           total_in   = '0;
                        end
                     end
                  end
               end
            end
         end
         lbps_pkg::ACT_START_BLINK: begin
            if (!running_ff) begin
               in_seq_in  = 1'b0;
               pos_in     = '0;
               total_in   = '0;
               on_in      = TIME_BITS'(ctl.item.on_time);
               off_in     = TIME_BITS'(ctl.item.off_time);
               rep_in     = ctl.item.repeat_count;
               forever_in = ctl.item.repeat_forever;
               toggles_in = '0;
               elapsed_in = '0;
               running_in = 1'b1;
               taken      = 1'b1;
            end
         end
         lbps_pkg::ACT_START_SEQ: begin
            if (!running_ff && len_ok) begin
               in_seq_in  = 1'b1;
               pos_in     = '0;
               total_in   = ctl.item.seq_length;
               on_in      = ent_on;
               off_in     = ent_off;
               rep_in     = ent_rep;
               forever_in = ent_forever;
               toggles_in = '0;
               elapsed_in = '0;
               running_in = 1'b1;
               taken      = 1'b1;
            end
         end
         lbps_pkg::ACT_STOP: begin
            if (running_ff) begin
               running_in = 1'b0;
               in_seq_in  = 1'b0;
               pos_in     = '0;
               total_in   = '0;
            end
         end
         lbps_pkg::ACT_SET_LED: begin
            led_in = ctl.item.led_level;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         led_ff     <= 1'b0;
         elapsed_ff <= '0;
         on_ff      <= '0;
         off_ff     <= '0;
         rep_ff     <= '0;
         forever_ff <= 1'b0;
         toggles_ff <= '0;
         in_seq_ff  <= 1'b0;
         pos_ff     <= '0;
         total_ff   <= '0;
      end else if (ctl.advance) begin
         running_ff <= running_in;
         led_ff     <= led_in;
         elapsed_ff <= elapsed_in;
         on_ff      <= on_in;
         off_ff     <= off_in;
         rep_ff     <= rep_in;
         forever_ff <= forever_in;
         toggles_ff <= toggles_in;
         in_seq_ff  <= in_seq_in;
         pos_ff     <= pos_in;
         total_ff   <= total_in;
      end
   end

   assign pos_after = ctl.valid ? pos_in : pos_ff;

   assign result.led_on      = led_in;
   assign result.blinking    = running_in;
   assign result.accepted    = taken;
   assign result.pattern_now = (running_in && in_seq_in) ? pos_in[lbps_pkg::SLOT_W-1:0] : '0;

endmodule

/* rtl/core/led_blink_pattern_sequencer_core.sv */
// A result passes the pattern table read stage, then the state update into the result register;
// a stalled output holds the request in the table read stage.
// Throughput: one request per cycle unless output stalls; the table read a stage ahead sets it.
// Reset: synchronous, active high; clears the blink state and both stage valids; the
// result data is not cleared. The pattern table is not cleared and holds garbage until written.
`timescale 1ns / 1ps
`include "led_blink_pattern_sequencer_core_assert.svh"

module led_blink_pattern_sequencer_core #(
   parameter int PATTERN_DEPTH = lbps_pkg::PATTERN_DEPTH_DEFAULT,
   parameter int TIME_BITS = lbps_pkg::TIME_BITS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   lbps_chan_if.sink   req_chan,
   lbps_chan_if.source rsp_chan
);

   localparam int ADDR_W  = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
   localparam int ENTRY_W = 2 * TIME_BITS + lbps_pkg::COUNT_W + 1;

   logic                       p_valid_ff, p_valid_in;
   lbps_pkg::req_type          p_item_ff;
   logic                       o_valid_ff, o_valid_in;
   lbps_pkg::rsp_type          o_data_ff;
   logic                       advance, accept, wr_en;
   logic [ADDR_W-1:0]          wr_addr, rd_addr;
   logic [ENTRY_W-1:0]         wr_data, rd_data;
   lbps_pkg::step_ctl_type     ctl;
   lbps_pkg::rsp_type          result;
   logic [lbps_pkg::LEN_W-1:0] pos_after;

   assign advance        = p_valid_ff && (!o_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !p_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   assign wr_en   = accept && (req_chan.data.action == lbps_pkg::ACT_WRITE) &&
                    (32'(req_chan.data.entry_index) < PATTERN_DEPTH);
   assign wr_addr = ADDR_W'(req_chan.data.entry_index);
   assign wr_data = {req_chan.data.repeat_forever, req_chan.data.repeat_count,
                     TIME_BITS'(req_chan.data.off_time), TIME_BITS'(req_chan.data.on_time)};
   assign rd_addr = (req_chan.data.action == lbps_pkg::ACT_START_SEQ) ? '0 :
                    ADDR_W'(pos_after + 1'b1);

   lbps_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (PATTERN_DEPTH),
      .ADDR_W(ADDR_W)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (accept),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign ctl.valid   = p_valid_ff;
   assign ctl.advance = advance;
   assign ctl.item    = p_item_ff;

   lbps_engine #(
      .TIME_BITS    (TIME_BITS),
      .PATTERN_DEPTH(PATTERN_DEPTH),
      .ENTRY_W      (ENTRY_W)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .entry    (rd_data),
      .result   (result),
      .pos_after(pos_after)
   );

   always_comb begin
      p_valid_in = p_valid_ff;
      if (accept) begin
         p_valid_in = 1'b1;
      end else if (advance) begin
         p_valid_in = 1'b0;
      end
      o_valid_in = o_valid_ff;
      if (advance) begin
         o_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         o_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= p_valid_in;
         o_valid_ff <= o_valid_in;
      end
      if (accept) begin
         p_item_ff <= req_chan.data;
      end
      if (advance) begin
         o_data_ff <= result;
      end
   end

   assign rsp_chan.valid = o_valid_ff;
   assign rsp_chan.data  = o_data_ff;

   `LBPS_ASSERT_NEVER(a_no_overwrite, clock, reset, accept && p_valid_ff && !advance)
   `LBPS_ASSERT_NEXT(a_stall_holds, clock, reset, p_valid_ff && !advance, p_valid_ff)
   `LBPS_ASSERT_NEXT(a_advance_fills, clock, reset, advance, o_valid_ff)

endmodule

/* test/lbps_blink_checker.sv */
`timescale 1ns / 1ps

module lbps_blink_checker
   import lbps_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      pending_results,
   output int      mismatch_count
);

   localparam int SLOTS = 16;
   localparam int PRINT_LIMIT = 30;

   typedef struct packed {
      logic [FIELD_W-1:0] on_ms;
      logic [FIELD_W-1:0] off_ms;
      logic [COUNT_W-1:0] toggles;
      logic               endless;
   } blink_pattern_t;

   logic               running;
   logic               led_now;
   logic               endless_now;
   logic               in_seq;
   logic [FIELD_W-1:0] elapsed;
   logic [FIELD_W-1:0] on_now;
   logic [FIELD_W-1:0] off_now;
   logic [COUNT_W-1:0] toggles_now;
   logic [COUNT_W-1:0] toggles_done;
   logic [SLOT_W-1:0]  seq_pos;
   logic [LEN_W-1:0]   seq_total;
   blink_pattern_t     pattern_mem [SLOTS];

   rsp_type led_status_q [$];

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      if (mismatch_count < PRINT_LIMIT)
         $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   function automatic void load_blink(input blink_pattern_t p);
      on_now       = p.on_ms;
      off_now      = p.off_ms;
      toggles_now  = p.toggles;
      endless_now  = p.endless;
      toggles_done = '0;
      elapsed      = '0;
      running      = 1'b1;
   endfunction

   function automatic void go_idle();
      running   = 1'b0;
      in_seq    = 1'b0;
      seq_pos   = '0;
      seq_total = '0;
   endfunction

   function automatic rsp_type next_led_status(input req_type r);
      rsp_type            s;
      logic               taken;
      logic [FIELD_W-1:0] wait_ms;
      taken = 1'b0;
      case (r.action)
         ACT_TICK: begin
            if (running) begin
               if (elapsed != '1) elapsed++;
               wait_ms = led_now ? on_now : off_now;
               if (elapsed >= wait_ms) begin
                  elapsed = '0;
                  led_now = !led_now;
                  if (!endless_now) begin
                     if (toggles_done != '1) toggles_done++;
                     if (toggles_done >= toggles_now) begin
                        if (in_seq && ({1'b0, seq_pos} + 5'd1 < seq_total)) begin
                           seq_pos++;
                           load_blink(pattern_mem[seq_pos]);
                        end else begin
                           go_idle();
                        end
                     end
                  end
               end
            end
         end
         ACT_START_BLINK: begin
            if (!running) begin
               in_seq    = 1'b0;
               seq_pos   = '0;
               seq_total = '0;
               load_blink('{r.on_time, r.off_time, r.repeat_count, r.repeat_forever});
               taken = 1'b1;
            end
         end
         ACT_START_SEQ: begin
            if (!running && r.seq_length >= 5'd1 && r.seq_length <= 5'(SLOTS)) begin
               in_seq    = 1'b1;
               seq_pos   = '0;
               seq_total = r.seq_length;
               load_blink(pattern_mem[0]);
               taken = 1'b1;
            end
         end
         ACT_STOP: begin
            if (running) go_idle();
         end
         ACT_WRITE: begin
            pattern_mem[r.entry_index] =
               '{r.on_time, r.off_time, r.repeat_count, r.repeat_forever};
         end
         ACT_SET_LED: begin
            led_now = r.led_level;
         end
         default: begin
         end
      endcase
      s.led_on      = led_now;
      s.blinking    = running;
      s.accepted    = taken;
      s.pattern_now = (running && in_seq) ? seq_pos : '0;
      return s;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         running      = 1'b0;
         led_now      = 1'b0;
         endless_now  = 1'b0;
         in_seq       = 1'b0;
         elapsed      = '0;
         on_now       = '0;
         off_now      = '0;
         toggles_now  = '0;
         toggles_done = '0;
         seq_pos      = '0;
         seq_total    = '0;
         for (int i = 0; i < SLOTS; i++) pattern_mem[i] = '0;
         led_status_q.delete();
      end else begin
         if (req_valid && req_ready) led_status_q.push_back(next_led_status(req_data));
         if (rsp_valid && rsp_ready) begin
            if (led_status_q.size() == 0) begin
               report_mismatch("result transfer with nothing expected", '0, '0);
            end else begin
               want = led_status_q.pop_front();
               if (rsp_data.led_on !== want.led_on)
                  report_mismatch("led_on", 16'(rsp_data.led_on), 16'(want.led_on));
               if (rsp_data.blinking !== want.blinking)
                  report_mismatch("blinking", 16'(rsp_data.blinking), 16'(want.blinking));
               if (rsp_data.accepted !== want.accepted)
                  report_mismatch("accepted", 16'(rsp_data.accepted), 16'(want.accepted));
               if (rsp_data.pattern_now !== want.pattern_now)
                  report_mismatch("pattern_now", 16'(rsp_data.pattern_now),
                                  16'(want.pattern_now));
            end
         end
      end
      pending_results <= led_status_q.size();
   end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import lbps_pkg::*;

   localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
   localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;
   localparam int RANDOM_ITEMS = 370;
   localparam int PAUSE_AT     = 200;
   localparam int STALL_LIMIT  = 3000;
   localparam int LONG_HOLD    = 150;
   localparam int DRAIN_CYCLES = 8;
   localparam int SLOTS        = 16;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int          pending_results;
   int          mismatch_count;
   int          stall_cycles = 0;
   int          results_taken = 0;
   bit [SLOTS-1:0] slot_written = '0;
   bit          req_calm = 1'b0;
   bit          rsp_calm = 1'b0;

   lbps_chan_if #(.payload_type(req_type)) req_chan ();
   lbps_chan_if #(.payload_type(rsp_type)) rsp_chan ();

   led_blink_pattern_sequencer_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   lbps_blink_checker blink_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_chan.valid),
      .req_ready       (req_chan.ready),
      .req_data        (req_chan.data),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_data        (rsp_chan.data),
      .pending_results (pending_results),
      .mismatch_count  (mismatch_count)
   );

   always #5 clock = ~clock;

   function automatic req_type make_cmd(input logic [ACT_W-1:0] act,
                                        input logic [15:0] on_ms,
                                        input logic [15:0] off_ms,
                                        input logic [15:0] toggles,
                                        input logic endless,
                                        input logic [SLOT_W-1:0] slot,
                                        input logic [LEN_W-1:0] len,
                                        input logic level);
      req_type c;
      c.action         = act;
      c.on_time        = on_ms;
      c.off_time       = off_ms;
      c.repeat_count   = toggles;
      c.repeat_forever = endless;
      c.entry_index    = slot;
      c.seq_length     = len;
      c.led_level      = level;
      return c;
   endfunction

   function automatic logic [15:0] pick_time();
      if ($urandom_range(0, 19) == 0) return 16'($urandom_range(0, 65535));
      return 16'($urandom_range(0, 4));
   endfunction

   function automatic logic [15:0] pick_toggles();
      if ($urandom_range(0, 19) == 0) return 16'($urandom_range(0, 65535));
      return 16'($urandom_range(0, 5));
   endfunction

   function automatic req_type random_cmd(input int ready_slots);
      req_type     c;
      logic [63:0] noise;
      int          pick;
      noise = {$urandom(), $urandom()};
      c = noise[$bits(req_type)-1:0];
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         c.action = ACT_TICK;
      end else if (pick < 62 || pick >= 76 && pick < 88) begin
         c.action         = (pick < 62) ? ACT_START_BLINK : ACT_WRITE;
         c.on_time        = pick_time();
         c.off_time       = pick_time();
         c.repeat_count   = pick_toggles();
         c.repeat_forever = ($urandom_range(0, 7) == 0);
         if (ready_slots < SLOTS && $urandom_range(0, 1) == 1)
            c.entry_index = SLOT_W'(ready_slots);
      end else if (pick < 72) begin
         c.action = ACT_START_SEQ;
         if (ready_slots > 0 && $urandom_range(0, 7) != 0)
            c.seq_length = LEN_W'($urandom_range(1, ready_slots));
         else if ($urandom_range(0, 1) == 1)
            c.seq_length = '0;
         else
            c.seq_length = LEN_W'($urandom_range(SLOTS + 1, 31));
      end else if (pick < 76) begin
         c.action = ACT_STOP;
      end else if (pick < 96) begin
         c.action = ACT_SET_LED;
      end else begin
         c.action = ($urandom_range(0, 1) == 1) ? ACT_SPARE_LO : ACT_SPARE_HI;
      end
      return c;
   endfunction

   task automatic send_item(input req_type item);
      int gap;
      if ($urandom_range(0, 31) == 0) req_calm = !req_calm;
      gap = req_calm ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data  <= item;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (item.action == ACT_WRITE) slot_written[item.entry_index] = 1'b1;
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   initial begin
      int ready_slots;
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(make_cmd(ACT_TICK, '1, '1, '1, 1'b1, '1, '1, 1'b1));
      send_item(make_cmd(ACT_STOP, '0, '0, '0, 1'b0, '0, '0, 1'b0));
      send_item(make_cmd(ACT_WRITE, 16'd0, 16'd0, 16'd0, 1'b0, 4'd0, '0, 1'b0));
      send_item(make_cmd(ACT_WRITE, 16'd1, 16'd2, 16'd3, 1'b0, 4'd1, '0, 1'b0));
      send_item(make_cmd(ACT_WRITE, 16'd2, 16'd0, 16'd1, 1'b0, 4'd2, '0, 1'b0));
      send_item(make_cmd(ACT_WRITE, '1, '1, '1, 1'b1, 4'd15, '1, 1'b1));
      send_item(make_cmd(ACT_START_SEQ, '0, '0, '0, 1'b0, '0, 5'd0, 1'b0));
      send_item(make_cmd(ACT_START_SEQ, '0, '0, '0, 1'b0, '0, 5'd31, 1'b0));
      send_item(make_cmd(ACT_START_BLINK, 16'd0, 16'd0, 16'd0, 1'b0, '0, '0, 1'b0));
      send_item(make_cmd(ACT_TICK, '0, '0, '0, 1'b0, '0, '0, 1'b0));
      send_item(make_cmd(ACT_START_BLINK, 16'd2, 16'd1, 16'd2, 1'b0, '0, '0, 1'b0));
      send_item(make_cmd(ACT_START_BLINK, 16'd5, 16'd5, 16'd5, 1'b0, '0, '0, 1'b0));
      send_item(make_cmd(ACT_START_SEQ, '0, '0, '0, 1'b0, '0, 5'd1, 1'b0));
      send_item(make_cmd(ACT_TICK, '0, '0, '0, 1'b0, '0, '0, 1'b0));
      send_item(make_cmd(ACT_SET_LED, '0, '0, '0, 1'b0, '0, '0, 1'b1));
      repeat (3) send_item(make_cmd(ACT_TICK, '0, '0, '0, 1'b0, '0, '0, 1'b0));
      send_item(make_cmd(ACT_STOP, '0, '0, '0, 1'b0, '0, '0, 1'b0));
      send_item(make_cmd(ACT_START_SEQ, '0, '0, '0, 1'b0, '0, 5'd3, 1'b0));
      repeat (6) send_item(make_cmd(ACT_TICK, '0, '0, '0, 1'b0, '0, '0, 1'b0));
      send_item(make_cmd(ACT_STOP, '0, '0, '0, 1'b0, '0, '0, 1'b0));
      send_item(make_cmd(ACT_START_BLINK, '1, '1, '1, 1'b1, '0, '0, 1'b0));
      send_item(make_cmd(ACT_STOP, '0, '0, '0, 1'b0, '0, '0, 1'b0));

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == PAUSE_AT) drain_results();
         ready_slots = 0;
         while (ready_slots < SLOTS && slot_written[ready_slots]) ready_slots++;
         send_item(random_cmd(ready_slots));
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("led_blink_pattern_sequencer_core: match");
      else
         $display("led_blink_pattern_sequencer_core: mismatch");
      $finish;
   end

   initial begin
      int hold;
      rsp_chan.ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 31) == 0) rsp_calm = !rsp_calm;
         hold = rsp_calm ? 0 : $urandom_range(0, 19);
         if (results_taken == 100 || results_taken == 300) hold = LONG_HOLD;
         if (hold > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         results_taken++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("led_blink_pattern_sequencer_core: mismatch");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule
